FILE: rtl/core/hfmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfmt_pkg: shared definitions for the hash frequency and mode tracker
// Table geometry, hash constant, result status codes and shared types.
// ----------------------------------------------------------------------------
package hfmt_pkg;

  // Number of hash slots. The slot index is taken as the low bits of the
  // hash product, so the size has to be a power of two.
  localparam int unsigned TABLE_SIZE = 8192;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned CNT_W      = 32;

  // Hash multiplier. Only its low index bits affect the slot number.
  localparam int unsigned HASH_MULT = 700000;
  localparam logic [IDX_W-1:0] HASH_MULT_LO = IDX_W'(HASH_MULT);

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;

  // One table slot as held in the memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } slot_t;

  // One result beat before it goes to the output register.
  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] key_count;
    logic [KEY_W-1:0] mode_key;
    logic [CNT_W-1:0] mode_count;
  } result_t;

  // Home slot of a key: (HASH_MULT * key mod 2^32) mod TABLE_SIZE.
  // With a power-of-two table only the low index bits of both factors matter.
  function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
    logic [2*IDX_W-1:0] prod;
    prod = k[IDX_W-1:0] * HASH_MULT_LO;
    return prod[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/core/hfmt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfmt_in_if: input channel of the tracker
// Valid/ready channel that carries one item kind and one key per beat.
// ----------------------------------------------------------------------------
interface hfmt_in_if;

  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] key_value;

  modport source (output valid, output kind, output key_value, input ready);
  modport sink   (input valid, input kind, input key_value, output ready);

endinterface

FILE: rtl/core/hfmt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfmt_out_if: result channel of the tracker
// Valid/ready channel that carries status, key count and the current mode.
// ----------------------------------------------------------------------------
interface hfmt_out_if;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        key_count;
  logic signed [31:0] mode_key;
  logic [31:0]        mode_count;

  modport source (output valid, output status, output key_count, output mode_key,
                  output mode_count, input ready);
  modport sink   (input valid, input status, input key_count, input mode_key,
                  input mode_count, output ready);

endinterface

FILE: rtl/core/hash_frequency_mode_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_frequency_mode_tracker_core: key frequency counter with mode tracking
// Open-addressed hash table with linear probing in a memory with one write
// and one read port, walked one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Beat contents
//   --------+-----+------------------------------------------------------
//   in_i    | in  | kind (insert or clear), key_value
//   out_o   | out | status, key_count, mode_key, mode_count (one per input)
//
// An insert probes from its home slot on, one slot per cycle on the memory
// read port, up to TABLE_SIZE slots; it then writes the key and its count in
// the update step and loads its result in the emit step before it returns to
// idle for the next item. A dropped item on a full table probes all TABLE_SIZE
// slots and skips the update step. A reserved zero key goes straight to the
// emit step. A clear item and reset both run a clearing pass over all
// TABLE_SIZE (8192) slots, one slot per cycle, while in_i.ready stays low.
// A finished result sits in the output register, so the next item can be
// accepted while out_o is stalled; a second result waits for that register.
// ----------------------------------------------------------------------------
module hash_frequency_mode_tracker_core import hfmt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  hfmt_in_if.sink    in_i,
  hfmt_out_if.source out_o
);

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_UPDATE = 5'b00100,
    S_EMIT   = 5'b01000,
    S_CLEAR  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] probes_q, probes_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic             emit_pend_q, emit_pend_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0] best_key_q, best_key_d;
  logic [CNT_W-1:0] best_count_q, best_count_d;
  result_t          res_q, res_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q, out_res_d;

  // Slot memory and its port.
  slot_t            mem [TABLE_SIZE];
  slot_t            rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_t            mem_wd;

  logic slot_hit;
  logic slot_empty;

  assign slot_hit   = (rd_q.key == key_q);
  assign slot_empty = (rd_q.key == '0);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    probes_d     = probes_q;
    clr_d        = clr_q;
    emit_pend_d  = emit_pend_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    best_key_d   = best_key_q;
    best_count_d = best_count_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    mem_we       = 1'b0;
    mem_wa       = pos_q;
    mem_wd       = '0;

    // The output register frees up when its beat is taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          if (in_i.kind) begin
            // Clear: drop the mode now, empty the slots in the pass.
            best_key_d   = '0;
            best_count_d = '0;
            res_d        = '{status: STAT_OK, key_count: '0, mode_key: '0,
                             mode_count: '0};
            emit_pend_d  = 1'b1;
            clr_d        = '0;
            state_d      = S_CLEAR;
          end else if (in_i.key_value == '0) begin
            res_d   = '{status: STAT_ZERO, key_count: '0, mode_key: best_key_q,
                        mode_count: best_count_q};
            state_d = S_EMIT;
          end else begin
            key_d    = $unsigned(in_i.key_value);
            pos_d    = home_slot($unsigned(in_i.key_value));
            probes_d = '0;
            state_d  = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        // rd_q holds the slot at pos_q.
        if (slot_hit || slot_empty) begin
          cnt_d   = (rd_q.count == '1) ? rd_q.count : rd_q.count + CNT_W'(1);
          state_d = S_UPDATE;
        end else if (probes_q == IDX_W'(TABLE_SIZE - 1)) begin
          res_d   = '{status: STAT_FULL, key_count: '0, mode_key: best_key_q,
                      mode_count: best_count_q};
          state_d = S_EMIT;
        end else begin
          pos_d    = pos_q + IDX_W'(1);
          probes_d = probes_q + IDX_W'(1);
        end
      end

      S_UPDATE: begin
        // Store the key and its new count, then refresh the mode.
        mem_we = 1'b1;
        mem_wa = pos_q;
        mem_wd = '{key: key_q, count: cnt_q};
        if (key_q == best_key_q) begin
          best_count_d = cnt_q;
        end else if (cnt_q > best_count_q) begin
          best_key_d   = key_q;
          best_count_d = cnt_q;
        end
        res_d   = '{status: STAT_OK, key_count: cnt_q, mode_key: best_key_d,
                    mode_count: best_count_d};
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = S_IDLE;
        end
      end

      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_SIZE - 1)) begin
          emit_pend_d = 1'b0;
          state_d     = emit_pend_q ? S_EMIT : S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts with a clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      emit_pend_q  <= 1'b0;
      best_key_q   <= '0;
      best_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      emit_pend_q  <= emit_pend_d;
      best_key_q   <= best_key_d;
      best_count_q <= best_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    probes_q  <= probes_d;
    key_q     <= key_d;
    cnt_q     <= cnt_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  // Slot memory: one write port, one registered read at the next probe slot.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[pos_d];
  end

  // Ports.
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_res_q.status;
  assign out_o.key_count  = out_res_q.key_count;
  assign out_o.mode_key   = $signed(out_res_q.mode_key);
  assign out_o.mode_count = out_res_q.mode_count;

  // A result beat only appears after the sequencer has emitted one.
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result beat raised outside the emit step");

  // Dropped or reserved items never report a key count.
  a_reject_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.status == STAT_FULL || out_res_q.status == STAT_ZERO)
    |-> out_res_q.key_count == '0)
    else $error("rejected item reports a nonzero count");

  // A tracked mode always has a nonzero count.
  a_mode_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_key_q != '0) |-> (best_count_q != '0))
    else $error("mode key held with a zero count");

  // A slot write for an insert always stores a live key and count.
  a_update_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE) |-> (key_q != '0 && cnt_q != '0))
    else $error("insert writes an empty slot");

endmodule
